/* rtl/core/csm_pkg.sv */
// Shared types for the class split matcher.
// Holds the byte classification struct and the result struct; no dependencies.
package csm_pkg;

  localparam int unsigned ResultOffsetBits = 16;

  localparam logic [2:0] CfgMode      = 3'd0;
  localparam logic [2:0] CfgClassBits0 = 3'd1;
  localparam logic [2:0] CfgClassBits1 = 3'd2;
  localparam logic [2:0] CfgClassBits2 = 3'd3;
  localparam logic [2:0] CfgClassBits3 = 3'd4;
  localparam logic [2:0] CfgSeparator = 3'd5;

  localparam logic ModePlus = 1'b0;
  localparam logic ModeStar = 1'b1;

  localparam logic [1:0] PhSearch = 2'd0;
  localparam logic [1:0] PhRun    = 2'd1;
  localparam logic [1:0] PhSep    = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  typedef struct packed {
    logic is_zero;
    logic is_class;
    logic is_sep;
  } byte_cls_t;

  typedef struct packed {
    logic                        matched;
    logic [ResultOffsetBits-1:0] whole_start;
    logic [ResultOffsetBits-1:0] whole_end;
    logic [ResultOffsetBits-1:0] grp1_start;
    logic [ResultOffsetBits-1:0] grp1_end;
    logic [ResultOffsetBits-1:0] grp2_start;
    logic [ResultOffsetBits-1:0] grp2_end;
    logic [ResultOffsetBits-1:0] grp3_start;
    logic [ResultOffsetBits-1:0] grp3_end;
    logic                        overflow;
  } result_t;

endpackage

/* rtl/core/csm_class_lookup.sv */
// Byte classifier: class membership, separator compare and terminator detect.
// Depends on csm_pkg for byte_cls_t.
module csm_class_lookup (
  input  logic [255:0]          class_vec_i,
  input  logic [7:0]            sep_i,
  input  logic [7:0]            byte_i,
  output csm_pkg::byte_cls_t    cls_o
);

  always_comb begin
    cls_o.is_zero  = (byte_i == 8'd0);
    // byte zero never belongs to the class, whatever bit 0 holds
    cls_o.is_class = !cls_o.is_zero && class_vec_i[byte_i];
    cls_o.is_sep   = (byte_i == sep_i);
  end

endmodule

/* rtl/core/csm_tracker.sv */
// Per-string match state and result formation.
// Depends on csm_pkg for phase codes, byte_cls_t and result_t.
module csm_tracker #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 mode_i,
  input  csm_pkg::byte_cls_t   cls_i,
  output csm_pkg::result_t     result_o
);

  localparam int unsigned ExtBits = (OFFSET_BITS > csm_pkg::ResultOffsetBits) ?
                                    OFFSET_BITS : csm_pkg::ResultOffsetBits;
  localparam int unsigned RB = csm_pkg::ResultOffsetBits;

  logic [1:0]             phase_q, phase_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] run_begin_q, run_begin_d;
  logic [OFFSET_BITS-1:0] sep_at_q, sep_at_d;
  logic [OFFSET_BITS-1:0] tail_q, tail_d;
  logic                   too_long_q, too_long_d;

  logic [ExtBits-1:0] pos_ext, run_ext, sep_ext, tail_ext;
  logic [RB-1:0]      len16, run16, sep16, tail16;
  logic               plus_done;

  // masked 16-bit views of the offsets
  assign pos_ext  = ExtBits'(pos_q);
  assign run_ext  = ExtBits'(run_begin_q);
  assign sep_ext  = ExtBits'(sep_at_q);
  assign tail_ext = ExtBits'(tail_q);
  assign len16    = pos_ext[RB-1:0];
  assign run16    = run_ext[RB-1:0];
  assign sep16    = sep_ext[RB-1:0];
  assign tail16   = tail_ext[RB-1:0];

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    run_begin_d = run_begin_q;
    sep_at_d    = sep_at_q;
    tail_d      = tail_q;
    too_long_d  = too_long_q;
    if (step_i) begin
      if (cls_i.is_zero) begin
        phase_d     = csm_pkg::PhSearch;
        pos_d       = '0;
        run_begin_d = '0;
        sep_at_d    = '0;
        tail_d      = '0;
        too_long_d  = 1'b0;
      end else if (pos_q == {OFFSET_BITS{1'b1}}) begin
        too_long_d = 1'b1;
      end else begin
        pos_d = pos_q + 1'b1;
        if (mode_i == csm_pkg::ModePlus) begin
          case (phase_q)
            csm_pkg::PhSearch: begin
              if (cls_i.is_class) begin
                run_begin_d = pos_q;
                phase_d     = csm_pkg::PhRun;
              end
            end
            csm_pkg::PhRun: begin
              if (cls_i.is_class) begin
                phase_d = csm_pkg::PhRun;
              end else if (cls_i.is_sep) begin
                sep_at_d = pos_q;
                phase_d  = csm_pkg::PhSep;
              end else begin
                phase_d = csm_pkg::PhSearch;
              end
            end
            csm_pkg::PhSep: begin
              if (!cls_i.is_sep) begin
                tail_d  = pos_q;
                phase_d = csm_pkg::PhDone;
              end
            end
            default: phase_d = phase_q;
          endcase
        end else if (phase_q != csm_pkg::PhDone && !cls_i.is_class) begin
          sep_at_d = pos_q;
          phase_d  = csm_pkg::PhDone;
        end
      end
    end
  end

  // result for a terminator seen against the current state
  assign plus_done = (phase_q == csm_pkg::PhSep) || (phase_q == csm_pkg::PhDone);

  always_comb begin
    result_o = '0;
    if (too_long_q) begin
      result_o.overflow = 1'b1;
    end else if (mode_i == csm_pkg::ModePlus) begin
      if (plus_done) begin
        result_o.matched     = 1'b1;
        result_o.whole_start = run16;
        result_o.whole_end   = len16;
        result_o.grp1_start  = sep16 - 1'b1;
        result_o.grp1_end    = sep16;
        result_o.grp2_start  = (phase_q == csm_pkg::PhSep) ? len16 : tail16;
        result_o.grp2_end    = len16;
      end
    end else if (phase_q == csm_pkg::PhDone) begin
      result_o.matched    = 1'b1;
      result_o.whole_end  = len16;
      result_o.grp1_end   = sep16;
      result_o.grp2_start = sep16;
      result_o.grp2_end   = sep16 + 1'b1;
      result_o.grp3_start = sep16 + 1'b1;
      result_o.grp3_end   = len16;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= csm_pkg::PhSearch;
      pos_q       <= '0;
      run_begin_q <= '0;
      sep_at_q    <= '0;
      tail_q      <= '0;
      too_long_q  <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      run_begin_q <= run_begin_d;
      sep_at_q    <= sep_at_d;
      tail_q      <= tail_d;
      too_long_q  <= too_long_d;
    end
  end

endmodule

/* rtl/core/class_split_matcher.sv */
// Class split matcher: one byte per cycle, one result per zero-terminated string.
// A terminator passes the input register, then the result register; a stalled result can hold it.
// Throughput: one byte per cycle while no terminator waits on a stalled result.
// A waiting result stalls a following terminator and the bytes after it, not earlier bytes.
// Reset (rst_ni low, asynchronous): config to defaults (separator 32), string state clear.
// Depends on csm_pkg, csm_class_lookup and csm_tracker.
module class_split_matcher #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  // result stream
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        matched_o,
  output logic [15:0] whole_start_o,
  output logic [15:0] whole_end_o,
  output logic [15:0] grp1_start_o,
  output logic [15:0] grp1_end_o,
  output logic [15:0] grp2_start_o,
  output logic [15:0] grp2_end_o,
  output logic [15:0] grp3_start_o,
  output logic [15:0] grp3_end_o,
  output logic        overflow_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  // configuration registers
  logic          mode_q;
  logic [255:0]  class_q;
  logic [7:0]    sep_q;

  // input register
  logic          in_valid_q;
  logic [7:0]    in_byte_q;

  // result register
  logic              out_valid_q;
  csm_pkg::result_t  out_q;

  csm_pkg::byte_cls_t cls;
  csm_pkg::result_t   result;
  logic               consume;
  logic               out_free;
  logic               in_accept;
  logic               cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= csm_pkg::ModePlus;
      class_q <= '0;
      sep_q   <= 8'd32;
    end else if (cfg_write) begin
      case (cfg_index_i)
        csm_pkg::CfgMode:       mode_q          <= cfg_data_i[0];
        csm_pkg::CfgClassBits0: class_q[63:0]    <= cfg_data_i;
        csm_pkg::CfgClassBits1: class_q[127:64]  <= cfg_data_i;
        csm_pkg::CfgClassBits2: class_q[191:128] <= cfg_data_i;
        csm_pkg::CfgClassBits3: class_q[255:192] <= cfg_data_i;
        csm_pkg::CfgSeparator:  sep_q           <= cfg_data_i[7:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Advance the held byte unless it is a terminator and the result slot
  // is still occupied by a stalled result.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign consume    = in_valid_q && (cls.is_zero == 1'b0 || out_free);
  assign in_stall_o = in_valid_q && !consume;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= text_byte_i;
    end
  end

  csm_class_lookup u_lookup (
    .class_vec_i (class_q),
    .sep_i       (sep_q),
    .byte_i      (in_byte_q),
    .cls_o       (cls)
  );

  csm_tracker #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_tracker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (consume),
    .mode_i   (mode_q),
    .cls_i    (cls),
    .result_o (result)
  );

  // Load the result slot on a consumed terminator; drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (consume && cls.is_zero) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && cls.is_zero) begin
      out_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign matched_o     = out_q.matched;
  assign whole_start_o = out_q.whole_start;
  assign whole_end_o   = out_q.whole_end;
  assign grp1_start_o  = out_q.grp1_start;
  assign grp1_end_o    = out_q.grp1_end;
  assign grp2_start_o  = out_q.grp2_start;
  assign grp2_end_o    = out_q.grp2_end;
  assign grp3_start_o  = out_q.grp3_start;
  assign grp3_end_o    = out_q.grp3_end;
  assign overflow_o    = out_q.overflow;

endmodule

/* dv/tb_class_split_matcher.sv */
// Self-checking testbench for class_split_matcher: byte streams in, split offsets out.
// Holds its own split predictor, directed and random tests; depends on csm_pkg and the RTL.
module tb_class_split_matcher;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned PosMax = (1 << OffsetBits) - 1;
  // Settling slack after the last expected split has arrived.
  localparam int unsigned DrainCycles = 6;
  // Longest legal quiet stretch is a long stall or gap plus latency.
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomBytes = 1500;
  // Byte values 'a'..'z' sit at bits 33..58 of the second class register.
  localparam logic [63:0] LowerCaseBits = ((64'h1 << 26) - 64'h1) << 33;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  text_byte = 8'h00;
  logic        result_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = csm_pkg::CfgMode;
  logic [63:0] cfg_data = 64'h0;

  logic        in_stall;
  logic        out_valid;
  logic        matched;
  logic [15:0] whole_start, whole_end;
  logic [15:0] grp1_start, grp1_end, grp2_start, grp2_end, grp3_start, grp3_end;
  logic        overflow;
  logic        cfg_ready;

  class_split_matcher #(
    .OFFSET_BITS(OffsetBits)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .text_byte_i  (text_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (result_stall),
    .matched_o    (matched),
    .whole_start_o(whole_start),
    .whole_end_o  (whole_end),
    .grp1_start_o (grp1_start),
    .grp1_end_o   (grp1_end),
    .grp2_start_o (grp2_start),
    .grp2_end_o   (grp2_end),
    .grp3_start_o (grp3_start),
    .grp3_end_o   (grp3_end),
    .overflow_o   (overflow),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Split predictor: shadow copy of the configuration and the per-string tracker.
  // ---------------------------------------------------------------------------
  logic        cfg_mode;
  logic [63:0] class_map [4];
  logic [7:0]  sep_char;

  logic [1:0]  trk_phase;
  int unsigned trk_pos;
  int unsigned trk_run_begin;
  int unsigned trk_sep_at;
  int unsigned trk_tail_begin;
  bit          trk_too_long;

  // Expected split results, oldest first.
  csm_pkg::result_t expected_splits [$];

  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  function automatic bit is_member(logic [7:0] b);
    // Zero always terminates, so it is never a class member.
    return (b != 8'h00) && class_map[b[7:6]][b[5:0]];
  endfunction

  function automatic void clear_tracker();
    trk_phase      = csm_pkg::PhSearch;
    trk_pos        = 0;
    trk_run_begin  = 0;
    trk_sep_at     = 0;
    trk_tail_begin = 0;
    trk_too_long   = 1'b0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [63:0] d);
    case (idx)
      csm_pkg::CfgMode:       cfg_mode = d[0];
      csm_pkg::CfgClassBits0: class_map[0] = d;
      csm_pkg::CfgClassBits1: class_map[1] = d;
      csm_pkg::CfgClassBits2: class_map[2] = d;
      csm_pkg::CfgClassBits3: class_map[3] = d;
      csm_pkg::CfgSeparator:  sep_char = d[7:0];
      default: ;
    endcase
  endfunction

  // Advance the tracker by one accepted byte; a terminator queues one result.
  function automatic void track_byte(logic [7:0] b);
    csm_pkg::result_t r;
    int unsigned      len;
    if (b != 8'h00) begin
      // Past the offset range: flag it and hold the position.
      if (trk_pos >= PosMax) begin
        trk_too_long = 1'b1;
        return;
      end
      if (cfg_mode == csm_pkg::ModePlus) begin
        case (trk_phase)
          csm_pkg::PhSearch: begin
            if (is_member(b)) begin
              trk_run_begin = trk_pos;
              trk_phase = csm_pkg::PhRun;
            end
          end
          csm_pkg::PhRun: begin
            // Class test wins over the separator test inside a run.
            if (!is_member(b)) begin
              if (b == sep_char) begin
                trk_sep_at = trk_pos;
                trk_phase = csm_pkg::PhSep;
              end else begin
                trk_phase = csm_pkg::PhSearch;
              end
            end
          end
          csm_pkg::PhSep: begin
            if (b != sep_char) begin
              trk_tail_begin = trk_pos;
              trk_phase = csm_pkg::PhDone;
            end
          end
          default: ;
        endcase
      end else if (trk_phase != csm_pkg::PhDone && !is_member(b)) begin
        // Star shape: any unfinished phase counts as still searching.
        trk_sep_at = trk_pos;
        trk_phase = csm_pkg::PhDone;
      end
      trk_pos++;
      return;
    end

    r = '0;
    len = trk_pos;
    if (trk_too_long) begin
      r.overflow = 1'b1;
    end else if (cfg_mode == csm_pkg::ModePlus) begin
      // A separator run reaching the end leaves an empty tail.
      if (trk_phase == csm_pkg::PhSep) begin
        trk_tail_begin = len;
        trk_phase = csm_pkg::PhDone;
      end
      if (trk_phase == csm_pkg::PhDone) begin
        r.matched     = 1'b1;
        r.whole_start = 16'(trk_run_begin);
        r.whole_end   = 16'(len);
        r.grp1_start  = 16'(trk_sep_at - 1);
        r.grp1_end    = 16'(trk_sep_at);
        r.grp2_start  = 16'(trk_tail_begin);
        r.grp2_end    = 16'(len);
      end
    end else if (trk_phase == csm_pkg::PhDone) begin
      r.matched     = 1'b1;
      r.whole_end   = 16'(len);
      r.grp1_end    = 16'(trk_sep_at);
      r.grp2_start  = 16'(trk_sep_at);
      r.grp2_end    = 16'(trk_sep_at + 1);
      r.grp3_start  = 16'(trk_sep_at + 1);
      r.grp3_end    = 16'(len);
    end
    expected_splits.push_back(r);
    clear_tracker();
  endfunction

  function automatic string describe_split(csm_pkg::result_t r);
    return $sformatf("m=%0d whole=[%0d,%0d) g1=[%0d,%0d) g2=[%0d,%0d) g3=[%0d,%0d) ovf=%0d",
                     r.matched, r.whole_start, r.whole_end, r.grp1_start, r.grp1_end,
                     r.grp2_start, r.grp2_end, r.grp3_start, r.grp3_end, r.overflow);
  endfunction

  // ---------------------------------------------------------------------------
  // Idle patterns: mostly short, now and then long, none when switched off.
  // ---------------------------------------------------------------------------
  function automatic int unsigned next_gap();
    int unsigned r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic next_stall();
    int unsigned r;
    if (stall_left != 0) begin
      stall_left--;
      return 1'b1;
    end
    if (!stalls_on) return 1'b0;
    r = $urandom_range(0, 99);
    if (r < 65) return 1'b0;
    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every transaction on the result side is compared against
  // the oldest expected split. It also owns the result-side stall.
  // ---------------------------------------------------------------------------
  csm_pkg::result_t got_split;
  csm_pkg::result_t want_split;

  always @(posedge clk) begin
    if (rst_n && out_valid && !result_stall) begin
      got_split = {matched, whole_start, whole_end, grp1_start, grp1_end,
                   grp2_start, grp2_end, grp3_start, grp3_end, overflow};
      if (expected_splits.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: result with nothing expected: %s", $time, describe_split(got_split));
        end
      end else begin
        want_split = expected_splits.pop_front();
        if (got_split !== want_split) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t: split mismatch", $time);
            $display("  expected %s", describe_split(want_split));
            $display("  actual   %s", describe_split(got_split));
          end
        end
      end
    end
    result_stall <= next_stall();
  end

  // Watchdog: count cycles in which no channel moves a transaction.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !result_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one byte; valid stays high when the next byte follows back to back.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    text_byte <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    track_byte(b);
    bytes_sent++;
    gap = next_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
    send_byte(8'h00);
  endtask

  // Hold the byte stream until every expected split is in, then let the pipe settle.
  task automatic hold_for_drain();
    in_valid <= 1'b0;
    while (expected_splits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] d);
    cfg_index <= idx;
    cfg_data <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte(bit want_member);
    logic [7:0] b;
    repeat (32) begin
      b = 8'($urandom_range(1, 255));
      if (is_member(b) == want_member && (want_member || b != sep_char)) return b;
    end
    return 8'($urandom_range(1, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset defaults with an empty string: nothing can match.
  task automatic test_empty_string();
    send_byte(8'h00);
  endtask

  // Plus shape on lowercase words with the default space separator: a clean split,
  // then a broken run followed by a run whose separator run reaches the end.
  task automatic test_plus_split();
    hold_for_drain();
    write_reg(csm_pkg::CfgClassBits1, LowerCaseBits);
    send_string("ab  c");
    send_string("x,y ");
  endtask

  // Separator that is also a class member, a zero separator, and the top byte value.
  task automatic test_separator_corners();
    hold_for_drain();
    write_reg(csm_pkg::CfgSeparator, 64'(8'h61));
    send_string("ba,");
    hold_for_drain();
    write_reg(csm_pkg::CfgSeparator, 64'h0);
    send_string("a");
    hold_for_drain();
    write_reg(csm_pkg::CfgSeparator, 64'hFF);
    send_byte(8'h7A);
    send_byte(8'hFF);
    send_byte(8'h71);
    send_byte(8'h00);
  endtask

  // Star shape: split at the first non-class byte, and a string with none.
  task automatic test_star_split();
    hold_for_drain();
    write_reg(csm_pkg::CfgMode, 64'(csm_pkg::ModeStar));
    send_string("a1b");
    send_string("ab");
  endtask

  // Flip the shape while a class run is open; the run must read as still searching.
  task automatic test_mode_switch_mid_string();
    hold_for_drain();
    write_reg(csm_pkg::CfgMode, 64'(csm_pkg::ModePlus));
    send_byte(8'h61);
    send_byte(8'h62);
    hold_for_drain();
    write_reg(csm_pkg::CfgMode, 64'(csm_pkg::ModeStar));
    send_string("1");
  endtask

  // One random string: mostly well-formed for the active shape, some pure noise.
  task automatic send_random_string();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind >= 7) begin
      repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(1, 255)));
    end else if (cfg_mode == csm_pkg::ModePlus) begin
      repeat ($urandom_range(0, 2)) send_byte(pick_byte(1'b0));
      // Sometimes a run that a stray byte breaks before the real one.
      if (kind < 2) begin
        repeat ($urandom_range(1, 3)) send_byte(pick_byte(1'b1));
        send_byte(pick_byte(1'b0));
      end
      repeat ($urandom_range(1, 5)) send_byte(pick_byte(1'b1));
      if (sep_char != 8'h00) begin
        repeat ($urandom_range(1, 3)) send_byte(sep_char);
      end
      repeat ($urandom_range(0, 5)) begin
        send_byte(($urandom_range(0, 4) == 0 && sep_char != 8'h00) ? sep_char
                                                                   : 8'($urandom_range(1, 255)));
      end
    end else begin
      repeat ($urandom_range(0, 5)) send_byte(pick_byte(1'b1));
      send_byte(pick_byte(1'b0));
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(1, 255)));
    end
    send_byte(8'h00);
  endtask

  // Random phases, each with its own configuration and idle pattern. The first two
  // use the extreme class maps and separators; one phase runs with no idling at all.
  task automatic test_random_phases();
    int unsigned phase_idx;
    int unsigned stop_at;
    logic [63:0] cls [4];
    logic [7:0]  sep;
    logic        shape;
    phase_idx = 0;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      case (phase_idx)
        0: begin
          shape = csm_pkg::ModePlus;
          sep = 8'hFF;
          foreach (cls[k]) cls[k] = '1;
        end
        1: begin
          shape = csm_pkg::ModeStar;
          sep = 8'h01;
          foreach (cls[k]) cls[k] = '0;
        end
        default: begin
          shape = logic'($urandom_range(0, 1));
          sep = 8'($urandom_range(1, 255));
          foreach (cls[k]) begin
            case ($urandom_range(0, 2))
              0: cls[k] = {$urandom, $urandom};
              1: cls[k] = {$urandom, $urandom} & {$urandom, $urandom};
              default: cls[k] = {$urandom, $urandom} | {$urandom, $urandom};
            endcase
          end
          // Keep the separator out of the class most of the time.
          if ($urandom_range(0, 4) != 0) cls[sep[7:6]][sep[5:0]] = 1'b0;
        end
      endcase
      gaps_on = (phase_idx == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      stalls_on = (phase_idx == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);

      hold_for_drain();
      write_reg(csm_pkg::CfgMode, 64'(shape));
      foreach (cls[k]) write_reg(3'(csm_pkg::CfgClassBits0 + k), cls[k]);
      write_reg(csm_pkg::CfgSeparator, 64'(sep));

      repeat (30) begin
        if (bytes_sent < stop_at) send_random_string();
      end
      phase_idx++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_mode = csm_pkg::ModePlus;
    foreach (class_map[k]) class_map[k] = '0;
    sep_char = 8'h20;
    clear_tracker();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_string();
    test_plus_split();
    test_separator_corners();
    test_star_split();
    test_mode_switch_mid_string();
    test_random_phases();

    hold_for_drain();
    if (fail_count == 0 && expected_splits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
